// ===== rtl/rat_pkg.sv =====
// Package with shared types and constants of the ack retransmit tracker.
package rat_pkg;
   localparam int SEQ_W = 16;
   localparam int TIME_W = 32;
   localparam int RETRY_W = 8;

   typedef enum logic [1:0] {
      KIND_SEND = 2'd0,
      KIND_ACK = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_QUEUED = 3'd0,
      EV_REJECTED = 3'd1,
      EV_ACKED = 3'd2,
      EV_RESEND = 3'd3,
      EV_DONE = 3'd4
   } event_type;

   localparam logic CSR_MIN_RESEND = 1'b0;
   localparam logic CSR_TABLE_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] ack_seq;
      logic [15:0] ack_mask;
      logic [15:0] tick_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [15:0] sequence_res;
      logic [7:0] retries;
      logic [31:0] rtt_ms;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] sent_at;
      logic [7:0] retries;
   } entry_type;
endpackage

// ===== rtl/rat_req_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface rat_req_if;
   import rat_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rat_rsp_if;
   import rat_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rat_table.sv =====
// Pending entry memory with one write port and one registered read port.
module rat_table #(
   parameter int DEPTH = 32
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input rat_pkg::entry_type wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output rat_pkg::entry_type rd_data
);
   import rat_pkg::*;
   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/rat_rtt.sv =====
// Update of the smoothed round trip estimate by reciprocal shift and add over four steps.
module rat_rtt (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [31:0] rtt,
   input logic [31:0] sample,
   output logic busy,
   output logic [31:0] result
);
   import rat_pkg::*;
   logic [35:0] x_ff, x_in;
   logic [35:0] q_ff, q_in;
   logic [2:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [35:0] q_a;
   logic [35:0] rem;

   assign busy = busy_ff;
   assign result = q_ff[31:0];

   always_comb begin
      x_in = x_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      q_a = '0;
      rem = '0;
      if (start) begin
         x_in = ({4'd0, rtt} << 3) + {4'd0, rtt} + {4'd0, sample};
         cnt_in = 3'd4;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (cnt_ff)
            3'd4: begin
               q_a = (x_ff >> 1) + (x_ff >> 2);
               q_in = q_a + (q_a >> 4);
            end
            3'd3: begin
               q_a = q_ff + (q_ff >> 8);
               q_in = q_a + (q_a >> 16);
            end
            3'd2: begin
               q_a = q_ff + (q_ff >> 32);
               q_in = q_a >> 3;
            end
            default: begin
               rem = x_ff - ((q_ff << 3) + (q_ff << 1));
               q_in = q_ff + {35'd0, rem > 36'd9};
            end
         endcase
         cnt_in = cnt_ff - 3'd1;
         busy_in = (cnt_ff != 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end
endmodule

// ===== rtl/reliable_ack_retransmit_tracker.sv =====
// Top level of the reliable message ack and retransmit tracker.
// A send passes from acceptance through the read and emit states before the next request is taken.
// An ack or tick reads each pending entry in turn through the read and evaluate states;
// a resent entry adds wait, an acked entry divide, move and wait; read and emit end the scan.
// One item is processed at a time; a result waiting in the response register stalls the scan.
// Synchronous reset clears counters, time, estimate and registers to defaults;
// entry memory is not cleared since only entries below the count are read.
module reliable_ack_retransmit_tracker #(
   parameter int PENDING_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   rat_req_if.sink req,
   rat_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [15:0] csr_write_data
);
   import rat_pkg::*;
   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int LW = (CW > 6) ? CW : 6;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_EVAL = 7'b0000100,
      ST_DIV = 7'b0001000,
      ST_MOVE = 7'b0010000,
      ST_EMIT = 7'b0100000,
      ST_WAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   req_type cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [15:0] nseq_ff, nseq_in, minr_ff, minr_in;
   logic [5:0] limit_ff, limit_in;
   logic [31:0] now_ff, now_in, rtt_ff, rtt_in;
   logic rv_ff, rv_in;
   rsp_type rp_ff, rp_in;
   entry_type hit_ff, hit_in;
   logic resume_ff, resume_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic div_start, div_busy;
   logic [31:0] div_result;
   logic [15:0] seq_gap;
   logic hit;
   logic [32:0] timeout;
   logic [31:0] age;
   logic [CW-1:0] lim;

   rat_table #(.DEPTH(2**AW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   rat_rtt u_rtt (
      .clock(clock), .reset(reset), .start(div_start), .rtt(rtt_ff),
      .sample(now_ff - rd_data.sent_at), .busy(div_busy), .result(div_result)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.payload = rp_ff;
   assign seq_gap = cur_ff.ack_seq - rd_data.seq;
   assign hit = (seq_gap == 16'd0) ||
                ((seq_gap <= 16'd16) && cur_ff.ack_mask[seq_gap[3:0] - 4'd1]);
   assign timeout = ({1'b0, rtt_ff} << 1) < {17'd0, minr_ff} ? {17'd0, minr_ff}
                                                            : ({1'b0, rtt_ff} << 1);
   assign age = now_ff - rd_data.sent_at;
   assign lim = (LW'(limit_ff) > LW'(PENDING_DEPTH)) ? CW'(PENDING_DEPTH) : CW'(limit_ff);

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      nseq_in = nseq_ff;
      now_in = now_ff;
      rtt_in = rtt_ff;
      rv_in = rv_ff;
      rp_in = rp_ff;
      hit_in = hit_ff;
      resume_in = resume_ff;
      minr_in = minr_ff;
      limit_in = limit_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      div_start = 1'b0;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      if (csr_write_enable) begin
         if (csr_index == CSR_MIN_RESEND) begin
            minr_in = csr_write_data;
         end else begin
            limit_in = csr_write_data[5:0];
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cur_in = req.payload;
               idx_in = '0;
               state_in = ST_READ;
               if (req.payload.kind == KIND_TICK) begin
                  now_in = now_ff + {16'd0, req.payload.tick_ms};
               end
            end
         end
         ST_READ: begin
            if (cur_ff.kind == KIND_SEND || cur_ff.kind == KIND_NONE ||
                idx_ff >= count_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cur_ff.kind == KIND_ACK && hit) begin
               hit_in = rd_data;
               div_start = 1'b1;
               state_in = ST_DIV;
            end else if (cur_ff.kind == KIND_TICK && {1'b0, age} > timeout) begin
               wr_en = 1'b1;
               wr_data.retries = rd_data.retries + 8'd1;
               wr_data.sent_at = now_ff;
               hit_in = wr_data;
               idx_in = idx_ff + 1'b1;
               resume_in = 1'b1;
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            rd_addr = AW'(count_ff - 1'b1);
            if (!div_busy) begin
               rtt_in = div_result;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            count_in = count_ff - 1'b1;
            resume_in = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rp_in.event_res = (cur_ff.kind == KIND_ACK) ? EV_ACKED : EV_RESEND;
               rp_in.sequence_res = hit_ff.seq;
               rp_in.retries = (cur_ff.kind == KIND_ACK) ? 8'd0 : hit_ff.retries;
               rp_in.rtt_ms = rtt_ff;
               rp_in.last = 1'b0;
               resume_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rp_in.rtt_ms = rtt_ff;
               rp_in.last = 1'b1;
               rp_in.retries = 8'd0;
               rp_in.sequence_res = 16'd0;
               rp_in.event_res = EV_DONE;
               state_in = ST_IDLE;
               if (cur_ff.kind == KIND_SEND) begin
                  rp_in.sequence_res = nseq_ff;
                  if (count_ff >= lim) begin
                     rp_in.event_res = EV_REJECTED;
                  end else begin
                     rp_in.event_res = EV_QUEUED;
                     wr_en = 1'b1;
                     wr_addr = count_ff[AW-1:0];
                     wr_data.seq = nseq_ff;
                     wr_data.sent_at = now_ff;
                     wr_data.retries = 8'd0;
                     count_in = count_ff + 1'b1;
                     nseq_in = nseq_ff + 16'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      rp_ff <= rp_in;
      hit_ff <= hit_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         nseq_ff <= '0;
         now_ff <= '0;
         rtt_ff <= '0;
         rv_ff <= 1'b0;
         resume_ff <= 1'b0;
         minr_ff <= 16'd100;
         limit_ff <= 6'd32;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         nseq_ff <= nseq_in;
         now_ff <= now_in;
         rtt_ff <= rtt_in;
         rv_ff <= rv_in;
         resume_ff <= resume_in;
         minr_ff <= minr_in;
         limit_ff <= limit_in;
      end
   end
endmodule

// ===== rtl/rat_checker.sv =====
// Port-level checker for the tracker, bound to the top level.
module rat_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_event,
   input logic rsp_last
);
   import rat_pkg::*;
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event == EV_DONE |-> rsp_last) else $error("done not last");
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accept while busy");
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event <= EV_DONE) else $error("bad event");
endmodule

bind reliable_ack_retransmit_tracker rat_checker u_rat_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_event(rsp.payload.event_res), .rsp_last(rsp.payload.last)
);

// ===== tb/rat_tb_checker.sv =====
// Checker that predicts the tracker's responses from observed transfers and compares them.
`timescale 1ns / 100ps
module rat_tb_checker
   import rat_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input req_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_payload,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [15:0] csr_write_data,
   output int mismatch_count,
   output int pending_rsp
);
   logic [15:0] slot_seq [32];
   logic [31:0] slot_sent [32];
   logic [7:0] slot_retry [32];
   int unsigned slot_count;
   logic [15:0] seq_next;
   logic [31:0] clock_ms;
   logic [31:0] rtt_est;
   logic [15:0] resend_floor;
   logic [5:0] limit_reg;
   rsp_type rsp_queue [$];

   assign pending_rsp = rsp_queue.size();

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic rsp_type make_rsp(event_type ev, logic [15:0] sq, logic [7:0] rt,
                                        logic fin);
      rsp_type r;
      r.event_res = ev;
      r.sequence_res = sq;
      r.retries = rt;
      r.rtt_ms = rtt_est;
      r.last = fin;
      return r;
   endfunction

   task automatic predict_tracker(input req_type q);
      int unsigned i;
      int unsigned lim;
      logic [15:0] seq_gap;
      logic [31:0] sample;
      logic [63:0] acc;
      logic [63:0] timeout;
      logic hit;
      case (kind_type'(q.kind))
         KIND_SEND: begin
            lim = limit_reg < 32 ? limit_reg : 32;
            if (slot_count >= lim) begin
               rsp_queue.push_back(make_rsp(EV_REJECTED, seq_next, 8'd0, 1'b1));
            end else begin
               slot_seq[slot_count] = seq_next;
               slot_sent[slot_count] = clock_ms;
               slot_retry[slot_count] = 8'd0;
               slot_count++;
               rsp_queue.push_back(make_rsp(EV_QUEUED, seq_next, 8'd0, 1'b1));
               seq_next = seq_next + 16'd1;
            end
         end
         KIND_ACK: begin
            i = 0;
            while (i < slot_count) begin
               seq_gap = q.ack_seq - slot_seq[i];
               hit = (seq_gap == 0) || (seq_gap <= 16 && q.ack_mask[seq_gap - 1]);
               if (hit) begin
                  sample = clock_ms - slot_sent[i];
                  acc = 64'(rtt_est) * 9 + 64'(sample);
                  rtt_est = 32'(acc / 10);
                  rsp_queue.push_back(make_rsp(EV_ACKED, slot_seq[i], 8'd0, 1'b0));
                  slot_seq[i] = slot_seq[slot_count - 1];
                  slot_sent[i] = slot_sent[slot_count - 1];
                  slot_retry[i] = slot_retry[slot_count - 1];
                  slot_count--;
               end else begin
                  i++;
               end
            end
            rsp_queue.push_back(make_rsp(EV_DONE, 16'd0, 8'd0, 1'b1));
         end
         KIND_TICK: begin
            timeout = 64'(rtt_est) * 2;
            clock_ms = clock_ms + 32'(q.tick_ms);
            if (timeout < 64'(resend_floor)) timeout = 64'(resend_floor);
            for (i = 0; i < slot_count; i++) begin
               if (64'(clock_ms - slot_sent[i]) > timeout) begin
                  slot_retry[i] = slot_retry[i] + 8'd1;
                  slot_sent[i] = clock_ms;
                  rsp_queue.push_back(make_rsp(EV_RESEND, slot_seq[i], slot_retry[i], 1'b0));
               end
            end
            rsp_queue.push_back(make_rsp(EV_DONE, 16'd0, 8'd0, 1'b1));
         end
         default: begin
            rsp_queue.push_back(make_rsp(EV_DONE, 16'd0, 8'd0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slot_count = 0;
         seq_next = 16'd0;
         clock_ms = 32'd0;
         rtt_est = 32'd0;
         resend_floor = 16'd100;
         limit_reg = 6'd32;
         mismatch_count = 0;
         rsp_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_MIN_RESEND) resend_floor = csr_write_data;
            else limit_reg = csr_write_data[5:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               report("unexpected response", 32'(rsp_payload.event_res), 32'd0);
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_payload.event_res !== want.event_res)
                  report("event", 32'(rsp_payload.event_res), 32'(want.event_res));
               if (rsp_payload.sequence_res !== want.sequence_res)
                  report("sequence", 32'(rsp_payload.sequence_res), 32'(want.sequence_res));
               if (rsp_payload.retries !== want.retries)
                  report("retries", 32'(rsp_payload.retries), 32'(want.retries));
               if (rsp_payload.rtt_ms !== want.rtt_ms)
                  report("rtt", rsp_payload.rtt_ms, want.rtt_ms);
               if (rsp_payload.last !== want.last)
                  report("last", 32'(rsp_payload.last), 32'(want.last));
            end
         end
         if (req_valid && req_ready) predict_tracker(req_payload);
      end
   end
endmodule

// ===== tb/tb_reliable_ack_retransmit_tracker.sv =====
// Top of the tracker testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb_reliable_ack_retransmit_tracker;
   import rat_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_write_data = 16'd0;
   int mismatch_count;
   int pending_rsp;
   int rsp_stall_left = 0;
   logic calm = 1'b0;
   logic [15:0] sent_seq = 16'd0;

   rat_req_if req ();
   rat_rsp_if rsp ();

   reliable_ack_retransmit_tracker uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   rat_tb_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count), .pending_rsp(pending_rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_stall_left <= $urandom_range(1, 19);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_item(input kind_type k, input logic [15:0] sq, input logic [15:0] mk,
                            input logic [15:0] tk);
      req_type q;
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      q.kind = k;
      q.ack_seq = sq;
      q.ack_mask = mk;
      q.tick_ms = tk;
      req.valid <= 1'b1;
      req.payload <= q;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (k == KIND_SEND) sent_seq = sent_seq + 16'd1;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_item();
      int pick;
      logic [15:0] back;
      pick = $urandom_range(0, 99);
      back = 16'($urandom_range(0, 17));
      if (pick < 45) send_item(KIND_SEND, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 70)
         send_item(KIND_ACK, sent_seq - 16'd1 - back, 16'($urandom), 16'($urandom));
      else if (pick < 75) send_item(KIND_ACK, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 93)
         send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)));
      else if (pick < 97) send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
      else send_item(KIND_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed part: fill to the limit, rejection, acks with edge masks, ticks.
      write_reg(CSR_TABLE_LIMIT, 16'd3);
      repeat (4) send_item(KIND_SEND, 16'd0, 16'd0, 16'd0);
      send_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'd150);
      send_item(KIND_TICK, 16'd0, 16'd0, 16'd0);
      send_item(KIND_ACK, 16'd18, 16'h8000, 16'hFFFF);
      send_item(KIND_ACK, 16'd2, 16'h0001, 16'd0);
      send_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_ACK, 16'd0, 16'd0, 16'd0);
      drain();
      write_reg(CSR_TABLE_LIMIT, 16'd0);
      write_reg(CSR_MIN_RESEND, 16'd0);
      send_item(KIND_SEND, 16'd0, 16'd0, 16'd0);
      send_item(KIND_TICK, 16'd0, 16'd0, 16'd1);
      drain();
      write_reg(CSR_TABLE_LIMIT, 16'd63);
      write_reg(CSR_MIN_RESEND, 16'd1);
      repeat (33) send_item(KIND_SEND, 16'd0, 16'd0, 16'd0);
      send_item(KIND_TICK, 16'd0, 16'd0, 16'd5);
      send_item(KIND_ACK, sent_seq - 16'd1, 16'hFFFF, 16'd0);
      send_item(KIND_ACK, sent_seq - 16'd18, 16'hFFFF, 16'd0);
      drain();
      // Random phases under varied register settings.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MIN_RESEND, 16'hFFFF); write_reg(CSR_TABLE_LIMIT, 16'd32); end
            1: begin write_reg(CSR_MIN_RESEND, 16'd50); write_reg(CSR_TABLE_LIMIT, 16'd1); end
            2: begin write_reg(CSR_MIN_RESEND, 16'd100); write_reg(CSR_TABLE_LIMIT, 16'd12); end
            default: write_reg(CSR_MIN_RESEND, 16'd20);
         endcase
         if (ph == 3) calm = 1'b1;
         repeat (15) random_item();
         drain();
      end
      // Many one-millisecond ticks over three entries drive retry counters past their wrap.
      write_reg(CSR_MIN_RESEND, 16'd0);
      write_reg(CSR_TABLE_LIMIT, 16'd32);
      repeat (3) send_item(KIND_SEND, 16'd0, 16'd0, 16'd0);
      repeat (256) send_item(KIND_TICK, 16'd0, 16'd0, 16'd1);
      drain();
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
